>>> rtl/pswq_pkg.sv
package pswq_pkg;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_INV   = 2'd3
  } stat_e;

  localparam int unsigned ENTRY_W = 50;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  queue_id;
    logic [1:0]  entry_type;
    logic [31:0] message_handle;
    logic [15:0] message_length;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  out_type;
    logic [31:0] out_handle;
    logic [15:0] out_length;
    logic [7:0]  backlog;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic idle;
    logic exec;
    logic pop;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic accept;
    logic clr_last;
    logic need_pop;
  } stat_t;

endpackage

>>> rtl/per_socket_write_queues_core.sv
// Channel | Valid      | Stall       | Payload
// input   | in_valid_i | in_stall_o  | in_data_i  (pswq_pkg::in_t)
// output  | out_valid_o| out_stall_i | out_data_o (pswq_pkg::out_t)
// Put, remove and failing commands go from idle to the execute state and back;
// a get that pops goes on to the pop state, since the head entry and its next
// link come from registered memory reads. After reset a clearing pass builds
// the free list; in_stall_o stays high meanwhile.
// One transaction is in work at a time; a pending result stalls the next
// transaction only while out_stall_i holds it.
module per_socket_write_queues_core #(
  parameter int unsigned NUM_QUEUES   = 64,
  parameter int unsigned POOL_ENTRIES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pswq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pswq_pkg::out_t out_data_o
);

  pswq_pkg::ctrl_t ctrl;
  pswq_pkg::stat_t stat;

  pswq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  pswq_dp #(
    .NUM_QUEUES   (NUM_QUEUES),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/pswq_ctrl.sv
module pswq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pswq_pkg::stat_t stat_i,
  output pswq_pkg::ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_EXEC,
    S_POP
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      case (state_q)
        S_CLR:  if (stat_i.clr_last) state_q <= S_IDLE;
        S_IDLE: if (stat_i.accept) state_q <= S_EXEC;
        S_EXEC: state_q <= stat_i.need_pop ? S_POP : S_IDLE;
        S_POP:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign ctrl_o.clr_en = (state_q == S_CLR);
  assign ctrl_o.idle   = (state_q == S_IDLE);
  assign ctrl_o.exec   = (state_q == S_EXEC);
  assign ctrl_o.pop    = (state_q == S_POP);

endmodule

>>> rtl/pswq_dp.sv
module pswq_dp #(
  parameter int unsigned NUM_QUEUES   = 64,
  parameter int unsigned POOL_ENTRIES = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pswq_pkg::ctrl_t ctrl_i,
  output pswq_pkg::stat_t stat_o,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pswq_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pswq_pkg::out_t  out_data_o
);

  localparam int unsigned EW   = $clog2(POOL_ENTRIES);
  localparam int unsigned CW   = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned QW   = $clog2(NUM_QUEUES);
  localparam int unsigned MAXD = (POOL_ENTRIES > NUM_QUEUES) ? POOL_ENTRIES : NUM_QUEUES;
  localparam int unsigned SW   = $clog2(MAXD);
  localparam int unsigned EDW  = pswq_pkg::ENTRY_W;

  logic [EW-1:0]  link_mem [POOL_ENTRIES];
  logic [EDW-1:0] ent_mem  [POOL_ENTRIES];
  logic [EW-1:0]  head_mem [NUM_QUEUES];
  logic [EW-1:0]  tail_mem [NUM_QUEUES];
  logic [CW-1:0]  cnt_mem  [NUM_QUEUES];

  logic [EW-1:0]  free_head_q, free_head_d;
  logic [CW-1:0]  free_cnt_q, free_cnt_d;
  logic [SW-1:0]  clr_q;
  logic           out_valid_q;
  pswq_pkg::out_t out_q, res_d;
  logic           res_load;

  logic [1:0]     cmd_q;
  logic [QW-1:0]  qidx_q;
  logic           qv_q;
  logic [EDW-1:0] data_q;
  logic [CW-1:0]  cnt_rd_q;
  logic [EW-1:0]  head_rd_q, tail_rd_q, link_rd_q;
  logic [EDW-1:0] ent_rd_q;

  logic           accept;
  logic [QW-1:0]  qidx_in;
  logic           qv_in;
  logic [EW-1:0]  link_ra;
  logic [CW-1:0]  cnt_m1;

  logic           link_we, cnt_we, head_we, tail_we, ent_we;
  logic [EW-1:0]  link_wa, link_wd, head_wd;
  logic [QW-1:0]  cnt_wa;
  logic [CW-1:0]  cnt_wd;

  assign in_stall_o = !ctrl_i.idle || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign qidx_in    = QW'(32'(in_data_i.queue_id));
  assign qv_in      = (in_data_i.queue_id != 6'd0) && (32'(in_data_i.queue_id) < NUM_QUEUES);
  assign link_ra    = ctrl_i.exec ? head_rd_q : free_head_q;
  assign cnt_m1     = cnt_rd_q - CW'(1);

  assign stat_o.accept   = accept;
  assign stat_o.clr_last = (32'(clr_q) == MAXD - 1);
  assign stat_o.need_pop = qv_q && (cmd_q == pswq_pkg::CMD_GET) && (cnt_rd_q != '0);

  // Capture the transaction and read the queue's descriptors
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_data_i.command;
      qidx_q    <= qidx_in;
      qv_q      <= qv_in;
      data_q    <= {in_data_i.entry_type, in_data_i.message_handle, in_data_i.message_length};
      cnt_rd_q  <= cnt_mem[qidx_in];
      head_rd_q <= head_mem[qidx_in];
      tail_rd_q <= tail_mem[qidx_in];
    end
    if (accept || ctrl_i.exec) link_rd_q <= link_mem[link_ra];
    if (ctrl_i.exec) ent_rd_q <= ent_mem[head_rd_q];
  end

  always_comb begin
    link_we     = 1'b0;
    link_wa     = '0;
    link_wd     = '0;
    cnt_we      = 1'b0;
    cnt_wa      = qidx_q;
    cnt_wd      = '0;
    head_we     = 1'b0;
    head_wd     = free_head_q;
    tail_we     = 1'b0;
    ent_we      = 1'b0;
    free_head_d = free_head_q;
    free_cnt_d  = free_cnt_q;
    res_load    = 1'b0;
    res_d       = '0;

    if (ctrl_i.clr_en) begin
      // Chain the pool as the free list, zero the queue counts
      link_we = (32'(clr_q) < POOL_ENTRIES);
      link_wa = clr_q[EW-1:0];
      link_wd = (32'(clr_q) == POOL_ENTRIES - 1) ? '0 : EW'(clr_q + SW'(1));
      cnt_we  = (32'(clr_q) < NUM_QUEUES);
      cnt_wa  = clr_q[QW-1:0];
    end else if (ctrl_i.exec) begin
      res_load = !stat_o.need_pop;
      // The unused command answers ok whatever the socket
      if (!qv_q && (cmd_q != pswq_pkg::CMD_NOP)) begin
        res_d.status = pswq_pkg::STAT_INV;
      end else begin
        case (cmd_q)
          pswq_pkg::CMD_PUT: begin
            if (free_cnt_q == '0) begin
              res_d.status = pswq_pkg::STAT_FULL;
            end else begin
              ent_we = 1'b1;
              if (cnt_rd_q == '0) begin
                head_we = 1'b1;
              end else begin
                link_we = 1'b1;
                link_wa = tail_rd_q;
                link_wd = free_head_q;
              end
              tail_we     = 1'b1;
              cnt_we      = 1'b1;
              cnt_wd      = cnt_rd_q + CW'(1);
              free_head_d = link_rd_q;
              free_cnt_d  = free_cnt_q - CW'(1);
            end
          end
          pswq_pkg::CMD_GET: begin
            if (cnt_rd_q == '0) res_d.status = pswq_pkg::STAT_EMPTY;
          end
          pswq_pkg::CMD_REMOVE: begin
            if (cnt_rd_q != '0) begin
              // Splice the whole queue in front of the free list
              link_we     = 1'b1;
              link_wa     = tail_rd_q;
              link_wd     = free_head_q;
              cnt_we      = 1'b1;
              free_head_d = head_rd_q;
              free_cnt_d  = free_cnt_q + cnt_rd_q;
            end
          end
          default: res_d.status = pswq_pkg::STAT_OK;
        endcase
      end
    end else if (ctrl_i.pop) begin
      res_load         = 1'b1;
      res_d.status     = pswq_pkg::STAT_OK;
      res_d.out_type   = ent_rd_q[EDW-1 -: 2];
      res_d.out_handle = ent_rd_q[47:16];
      res_d.out_length = ent_rd_q[15:0];
      res_d.backlog    = (32'(cnt_m1) > 255) ? 8'hFF : 8'(cnt_m1);
      head_we          = 1'b1;
      head_wd          = link_rd_q;
      cnt_we           = 1'b1;
      cnt_wd           = cnt_m1;
      link_we          = 1'b1;
      link_wa          = head_rd_q;
      link_wd          = free_head_q;
      free_head_d      = head_rd_q;
      free_cnt_d       = free_cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (head_we) head_mem[qidx_q] <= head_wd;
    if (tail_we) tail_mem[qidx_q] <= free_head_q;
    if (ent_we) ent_mem[free_head_q] <= data_q;
    if (res_load) out_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      free_cnt_q  <= CW'(POOL_ENTRIES);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      if (ctrl_i.clr_en) clr_q <= clr_q + SW'(1);
      if (res_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_cnt_q) <= POOL_ENTRIES) else $error("free count above pool size");

  a_stall_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clr_en |-> in_stall_o) else $error("input taken during clearing pass");

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.exec) || $past(ctrl_i.pop))
    else $error("result without command");

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !out_valid_q || !out_stall_i) else $error("result overwrites pending one");

endmodule
